FILE: rtl/lfu_pkg.sv
package lfu_pkg;
	localparam int ENTRIES    = 16;
	localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_BITS   = $clog2(ENTRIES + 1);
	localparam int COUNT_BITS = 16;
	localparam int KEY_BITS   = 31;
	localparam int VAL_BITS   = 31;
	localparam int CAP_BITS   = 5;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE,
		ST_OUT
	} lfu_state_t;

	typedef struct packed {
		logic load;
		logic update;
	} lfu_cmd_t;
endpackage

FILE: rtl/lfu_ctrl.sv
module lfu_ctrl import lfu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  logic     out_fire,
	output logic     busy,
	output logic     res_valid,
	output lfu_cmd_t cmd
);
	lfu_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_fire) state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_OUT;
			ST_OUT:    if (out_fire) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load   = 1'b0;
		cmd.update = 1'b0;
		busy       = 1'b1;
		res_valid  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = in_fire;
			end
			ST_UPDATE: cmd.update = 1'b1;
			ST_OUT:    res_valid = 1'b1;
			default:   ;
		endcase
	end
endmodule

FILE: rtl/lfu_dp.sv
module lfu_dp import lfu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  lfu_cmd_t            cmd,
	input  logic [CAP_BITS-1:0] capacity,
	input  logic                func,
	input  logic [KEY_BITS-1:0] key,
	input  logic [VAL_BITS-1:0] value,
	output logic                hit,
	output logic [VAL_BITS-1:0] read_value
);
	logic [ENTRIES-1:0]   valid_q;
	logic [KEY_BITS-1:0]  key_q   [ENTRIES];
	logic [VAL_BITS-1:0]  val_q   [ENTRIES];
	logic [COUNT_BITS-1:0] cnt_q  [ENTRIES];
	logic [IDX_BITS-1:0]  rank_q  [ENTRIES];
	logic [OCC_BITS-1:0]  occ_q;

	logic                func_q;
	logic [KEY_BITS-1:0] ikey_q;
	logic [VAL_BITS-1:0] ival_q;

	// lookup stage results
	logic                found_s1, victim_ok_s1, free_ok_s1, evict_s1;
	logic [IDX_BITS-1:0] found_idx_s1, victim_s1, free_s1;

	logic                found;
	logic [IDX_BITS-1:0] found_idx, victim, free_idx;
	logic                victim_ok, free_ok;
	logic [OCC_BITS-1:0] cap_eff;

	// victim search tree nodes
	logic                tv   [ENTRIES];
	logic [IDX_BITS-1:0] tidx [ENTRIES];

	always_comb begin
		found = 1'b0; found_idx = '0;
		for (int j = ENTRIES - 1; j >= 0; j--) begin
			if (valid_q[j] && key_q[j] == ikey_q) begin
				found = 1'b1; found_idx = IDX_BITS'(j);
			end
		end
	end

	always_comb begin
		free_ok = 1'b0; free_idx = '0;
		for (int j = ENTRIES - 1; j >= 0; j--) begin
			if (!valid_q[j]) begin
				free_ok = 1'b1; free_idx = IDX_BITS'(j);
			end
		end
	end

	// oldest-lowest search as a pairwise tree: ranks are unique among valid entries
	always_comb begin
		for (int j = 0; j < ENTRIES; j++) begin
			tv[j]   = valid_q[j];
			tidx[j] = IDX_BITS'(j);
		end
		for (int w = 1; w < ENTRIES; w = w * 2) begin
			for (int j = 0; j + w < ENTRIES; j = j + 2 * w) begin
				if (tv[j + w] && (!tv[j] || cnt_q[tidx[j + w]] < cnt_q[tidx[j]] ||
						(cnt_q[tidx[j + w]] == cnt_q[tidx[j]] &&
						rank_q[tidx[j + w]] > rank_q[tidx[j]]))) begin
					tv[j]   = 1'b1;
					tidx[j] = tidx[j + w];
				end
			end
		end
		victim_ok = tv[0];
		victim    = tidx[0];
	end

	always_comb begin
		if ({1'b0, capacity} > (CAP_BITS+1)'(ENTRIES)) cap_eff = OCC_BITS'(ENTRIES);
		else cap_eff = OCC_BITS'(capacity);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			ikey_q <= key;
			ival_q <= value;
		end
		found_s1     <= found;
		found_idx_s1 <= found_idx;
		victim_s1    <= victim;
		victim_ok_s1 <= victim_ok;
		free_s1      <= free_idx;
		free_ok_s1   <= free_ok;
		evict_s1     <= (occ_q >= cap_eff);
	end

	// insert target after optional eviction
	logic                do_ins, do_evict;
	logic [IDX_BITS-1:0] ins_idx;
	always_comb begin
		do_ins   = !found_s1 && func_q && (cap_eff != '0);
		do_evict = do_ins && evict_s1 && victim_ok_s1;
		if (do_evict) ins_idx = victim_s1;
		else ins_idx = free_s1;
		if (do_ins && !do_evict && !free_ok_s1) do_ins = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int j = 0; j < ENTRIES; j++) rank_q[j] <= '0;
		end else if (cmd.update) begin
			if (found_s1) begin
				for (int j = 0; j < ENTRIES; j++) begin
					if (valid_q[j] && rank_q[j] < rank_q[found_idx_s1])
						rank_q[j] <= rank_q[j] + 1'b1;
				end
				rank_q[found_idx_s1] <= '0;
			end else if (do_ins) begin
				for (int j = 0; j < ENTRIES; j++) begin
					if (valid_q[j] && !(do_evict && rank_q[j] > rank_q[victim_s1]))
						rank_q[j] <= rank_q[j] + 1'b1;
				end
				rank_q[ins_idx] <= '0;
				valid_q[ins_idx] <= 1'b1;
				if (!do_evict) occ_q <= occ_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (found_s1) begin
				if (cnt_q[found_idx_s1] != COUNT_MAX)
					cnt_q[found_idx_s1] <= cnt_q[found_idx_s1] + 1'b1;
				if (func_q) val_q[found_idx_s1] <= ival_q;
			end else if (do_ins) begin
				key_q[ins_idx] <= ikey_q;
				val_q[ins_idx] <= ival_q;
				cnt_q[ins_idx] <= COUNT_BITS'(1);
			end
			hit        <= found_s1;
			read_value <= (found_s1 && !func_q) ? val_q[found_idx_s1] : '0;
		end
	end
endmodule

FILE: rtl/lfu_cache_with_lru_tiebreak.sv
// Flow: an accepted input transaction passes through the lookup and update
// states; the result is then held valid in the output state until it is taken.
// Items are handled one at a time (accept, lookup, update, output); a new input
// is accepted only once the result of the last one has been taken.
// Reset: arst_n clears all entries to invalid, occupancy to 0, capacity to 16.
module lfu_cache_with_lru_tiebreak import lfu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // func, key[31], value[31], pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // hit, read_value[31]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);
	logic [CAP_BITS-1:0] cap_q;
	logic                busy, res_valid, hit;
	logic [VAL_BITS-1:0] read_value;
	lfu_cmd_t            cmd;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !busy;
	assign m_axis_tvalid = res_valid;
	assign m_axis_tdata  = {read_value, hit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= CAP_BITS'(16);
		else if (cfg_valid) cap_q <= cfg_data;
	end

	lfu_ctrl u_ctrl (
		.clk, .arst_n,
		.in_fire  (s_axis_tvalid && s_axis_tready),
		.out_fire (m_axis_tvalid && m_axis_tready),
		.busy, .res_valid, .cmd
	);

	lfu_dp u_dp (
		.clk, .arst_n, .cmd,
		.capacity   (cap_q),
		.func       (s_axis_tdata[0]),
		.key        (s_axis_tdata[31:1]),
		.value      (s_axis_tdata[62:32]),
		.hit, .read_value
	);
endmodule

FILE: rtl/lfu_checker.sv
module lfu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken during result");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
		else $error("result too early");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tdata[31:1] == '0)
		else $error("miss with value");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
endmodule

bind lfu_cache_with_lru_tiebreak lfu_checker u_chk (.*);

FILE: tb/sv/tb_top.sv
module tb_top import lfu_pkg::*; ;

	localparam bit OP_GET = 1'b0;
	localparam bit OP_PUT = 1'b1;

	typedef struct packed {
		logic [VAL_BITS-1:0] rd;
		logic                hit;
	} lookup_res_t;

	typedef struct {
		bit                  op;
		logic [KEY_BITS-1:0] key;
		logic [VAL_BITS-1:0] val;
		bit                  has_exp;
		logic                exp_hit;
		logic [VAL_BITS-1:0] exp_rd;
	} drow_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [31:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	wire         cfg_ready;
	logic [4:0]  cfg_data = '0;

	lfu_cache_with_lru_tiebreak DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// shadow store
	logic [CAP_BITS-1:0]   cap_q;
	bit                    sv_valid [ENTRIES];
	logic [KEY_BITS-1:0]   sv_key   [ENTRIES];
	logic [VAL_BITS-1:0]   sv_val   [ENTRIES];
	logic [COUNT_BITS-1:0] sv_cnt   [ENTRIES];
	int unsigned           sv_rank  [ENTRIES];
	int unsigned           sv_occ;

	lookup_res_t pending_res[$];
	int          errors = 0;
	bit          rx_quiet = 0;

	function automatic lookup_res_t lfu_access(bit op, logic [KEY_BITS-1:0] k,
			logic [VAL_BITS-1:0] v);
		lookup_res_t r;
		int found, ecap, victim, r0;
		r = '0;
		found = -1;
		ecap = (cap_q > ENTRIES) ? ENTRIES : int'(cap_q);
		for (int j = 0; j < ENTRIES; j++)
			if (found < 0 && sv_valid[j] && sv_key[j] == k) found = j;
		if (found >= 0) begin
			if (sv_cnt[found] != COUNT_MAX) sv_cnt[found]++;
			r0 = sv_rank[found];
			for (int j = 0; j < ENTRIES; j++)
				if (sv_valid[j] && j != found && sv_rank[j] < r0) sv_rank[j]++;
			sv_rank[found] = 0;
			r.hit = 1'b1;
			if (op == OP_PUT) sv_val[found] = v;
			else r.rd = sv_val[found];
			return r;
		end
		if (op == OP_GET || ecap == 0) return r;
		if (sv_occ >= ecap) begin
			victim = -1;
			for (int j = 0; j < ENTRIES; j++)
				if (sv_valid[j] && (victim < 0 || sv_cnt[j] < sv_cnt[victim] ||
						(sv_cnt[j] == sv_cnt[victim] && sv_rank[j] > sv_rank[victim])))
					victim = j;
			if (victim >= 0) begin
				r0 = sv_rank[victim];
				for (int j = 0; j < ENTRIES; j++)
					if (sv_valid[j] && j != victim && sv_rank[j] > r0) sv_rank[j]--;
				sv_valid[victim] = 0;
				sv_rank[victim] = 0;
				sv_occ--;
			end
		end
		for (int j = 0; j < ENTRIES; j++)
			if (!sv_valid[j]) begin
				for (int i = 0; i < ENTRIES; i++)
					if (sv_valid[i]) sv_rank[i]++;
				sv_valid[j] = 1;
				sv_key[j] = k;
				sv_val[j] = v;
				sv_cnt[j] = 1;
				sv_rank[j] = 0;
				sv_occ++;
				break;
			end
		return r;
	endfunction

	task automatic idle_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
			(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
		repeat (g) @(posedge clk);
	endtask

	task automatic send_item(bit op, logic [KEY_BITS-1:0] k, logic [VAL_BITS-1:0] v,
			bit has_exp, logic eh, logic [VAL_BITS-1:0] ev);
		lookup_res_t r;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, v, k, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		r = lfu_access(op, k, v);
		if (has_exp && (r.hit !== eh || r.rd !== ev)) begin
			$display("%0t table row model: exp hit=%0b rd=%0h got hit=%0b rd=%0h",
				$time, eh, ev, r.hit, r.rd);
			errors++;
		end
		pending_res.push_back(r);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_capacity(logic [4:0] c);
		while (pending_res.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= c;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cap_q = c;
		cfg_valid <= 1'b0;
	endtask

	// receiver
	always @(posedge clk) begin
		lookup_res_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_res.size() == 0) begin
				$display("%0t unexpected result %h", $time, m_axis_tdata);
				errors++;
			end else begin
				want = pending_res.pop_front();
				if (got.hit !== want.hit) begin
					$display("%0t hit: exp %0b act %0b", $time, want.hit, got.hit);
					errors++;
				end
				if (got.rd !== want.rd) begin
					$display("%0t read_value: exp %h act %h", $time, want.rd, got.rd);
					errors++;
				end
			end
		end
		m_axis_tready <= rx_quiet ? 1'b1 : ($urandom_range(0, 9) == 0) ? 1'b0 :
			($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) if (arst_n) begin
		if ($urandom_range(0, 199) == 0) rx_quiet <= ~rx_quiet;
	end

	drow_t dir_rows[$];

	task automatic add_row(bit op, int k, int v, bit he, logic eh, int ev);
		drow_t d;
		d.op = op; d.key = KEY_BITS'(k); d.val = VAL_BITS'(v); d.has_exp = he;
		d.exp_hit = eh; d.exp_rd = VAL_BITS'(ev);
		dir_rows.push_back(d);
	endtask

	task automatic random_phase(int n, int keyspan);
		bit op;
		logic [KEY_BITS-1:0] k;
		for (int i = 0; i < n; i++) begin
			op = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 15) == 0) k = KEY_BITS'({$urandom} >> 1);
			else k = KEY_BITS'($urandom_range(0, keyspan)) ^ (($urandom_range(0, 7) == 0) ?
				31'h7FFF_FFF0 : 31'h0);
			send_item(op, k, VAL_BITS'({$urandom} >> 1), 0, 0, 0);
			if (!rx_quiet) idle_gap();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cap_q = 16;
		sv_occ = 0;
		for (int j = 0; j < ENTRIES; j++) begin
			sv_valid[j] = 0; sv_rank[j] = 0; sv_cnt[j] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(OP_GET, 0, 0, 1, 0, 0);
		add_row(OP_PUT, 0, 31'h7FFFFFFF, 1, 0, 0);
		add_row(OP_GET, 0, 0, 1, 1, 31'h7FFFFFFF);
		add_row(OP_PUT, 31'h7FFFFFFF, 0, 1, 0, 0);
		add_row(OP_GET, 31'h7FFFFFFF, 31'h7FFFFFFF, 1, 1, 0);
		add_row(OP_PUT, 0, 31'h5555_5555, 1, 1, 0);
		add_row(OP_GET, 0, 0, 1, 1, 31'h5555_5555);
		add_row(OP_GET, 31'h2AAA_AAAA, 0, 1, 0, 0);
		for (int i = 1; i <= 16; i++) add_row(OP_PUT, i, i * 3, 0, 0, 0);
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].val,
				dir_rows[i].has_exp, dir_rows[i].exp_hit, dir_rows[i].exp_rd);
			idle_gap();
		end

		random_phase(300, 24);
		write_capacity(5'd0);
		send_item(OP_PUT, 31'h1234, 7, 0, 0, 0);
		random_phase(100, 24);
		write_capacity(5'd3);
		random_phase(250, 8);
		write_capacity(5'd31);
		random_phase(250, 30);
		write_capacity(5'd1);
		random_phase(150, 4);
		write_capacity(5'd8);
		random_phase(300, 12);
		write_capacity(5'd16);
		random_phase(150, 20);

		while (pending_res.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#4000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
